>>> rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and constants shared by the WebSocket frame deframer modules.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int LEN_W = 27;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_MASK,
    PH_PAY,
    PH_HALT
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_PING  = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  localparam logic [2:0] CAUSE_NONE       = 3'd0;
  localparam logic [2:0] CAUSE_UNMASKED   = 3'd1;
  localparam logic [2:0] CAUSE_TOO_LONG   = 3'd2;
  localparam logic [2:0] CAUSE_BAD_CTRL   = 3'd3;
  localparam logic [2:0] CAUSE_ORPHAN     = 3'd4;
  localparam logic [2:0] CAUSE_INTERLEAVE = 3'd5;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [6:0] LEN_CTRL_MAX = 7'd125;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 27'd67108864;

  // one result word, as it travels through the queue
  typedef struct packed {
    logic [1:0] kind;
    logic       has_byte;
    logic [7:0] payload_byte;
    logic       is_binary;
    logic       frame_end;
    logic       message_end;
    logic [2:0] error_cause;
  } result_t;

endpackage

>>> rtl/wsd_front.sv
// ----------------------------------------------------------------------------
// wsd_front
// Header parser and unmasker: takes one raw byte a cycle while in_take is
// high and produces at most one result word for it.
// ----------------------------------------------------------------------------
module wsd_front
  import wsd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_data,
  input  logic             in_take,
  input  logic [7:0]       in_byte,
  output logic             res_valid,
  output result_t          res
);

  phase_t            phase, phase_next;
  logic              fin_bit;
  logic [3:0]        frame_opcode;
  logic [LEN_W-1:0]  length_low;   // low 27 bits of the length
  logic              length_big;   // any length bit above bit 26 was set
  logic [3:0]        length_bytes_left;
  logic [31:0]       mask_key;
  logic [LEN_W-1:0]  payload_left;
  logic [1:0]        mask_index;
  logic              in_fragment;
  logic              first_is_binary;
  logic [LEN_W-1:0]  max_frame_len;

  logic [1:0] fkind;
  logic       is_data, is_pong, is_ctrl;
  logic [31:0] key_full;
  logic       too_long, bad_ctrl, orphan, interleave;
  logic [7:0] ub;
  logic       last;

  // classify the current opcode
  always_comb begin
    is_pong = (frame_opcode == OP_PONG);
    is_data = (frame_opcode <= OP_BINARY);
    is_ctrl = (frame_opcode == OP_CLOSE) || (frame_opcode == OP_PING) || is_pong;
    if (is_data) fkind = KIND_DATA;
    else if (frame_opcode == OP_PING) fkind = KIND_PING;
    else fkind = KIND_CLOSE;
  end

  // header checks on the completed length and key
  always_comb begin
    key_full   = {mask_key[23:0], in_byte};
    too_long   = length_big || (length_low > max_frame_len);
    bad_ctrl   = is_ctrl && (!fin_bit || (length_low > LEN_W'(LEN_CTRL_MAX)));
    orphan     = (frame_opcode == OP_CONT) && !in_fragment;
    interleave = ((frame_opcode == OP_TEXT) || (frame_opcode == OP_BINARY)) && in_fragment;
    ub   = in_byte ^ mask_key[8*(3-mask_index) +: 8];
    last = (payload_left == LEN_W'(1));
  end

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HDR0: phase_next = PH_HDR1;
      PH_HDR1: begin
        if (!in_byte[7]) phase_next = PH_HALT;
        else if (in_byte[6:0] == LEN_EXT16 || in_byte[6:0] == LEN_EXT64)
          phase_next = PH_EXT;
        else phase_next = PH_MASK;
      end
      PH_EXT:  if (length_bytes_left == 4'd1) phase_next = PH_MASK;
      PH_MASK: begin
        if (mask_index == 2'd3) begin
          if (too_long || bad_ctrl || orphan || interleave) phase_next = PH_HALT;
          else if (length_low == '0) phase_next = PH_HDR0;
          else phase_next = PH_PAY;
        end
      end
      PH_PAY:  if (last) phase_next = PH_HDR0;
      PH_HALT: phase_next = PH_HALT;
      default: phase_next = PH_HDR0;
    endcase
  end

  // result word for this byte
  always_comb begin
    res_valid = 1'b0;
    res = '0;
    unique case (phase)
      PH_HDR1: begin
        if (!in_byte[7]) begin
          res_valid = in_take;
          res.kind = KIND_ERROR;
          res.error_cause = CAUSE_UNMASKED;
        end
      end
      PH_MASK: begin
        if (mask_index == 2'd3) begin
          res.kind = KIND_ERROR;
          if (too_long) begin
            res_valid = in_take; res.error_cause = CAUSE_TOO_LONG;
          end else if (bad_ctrl) begin
            res_valid = in_take; res.error_cause = CAUSE_BAD_CTRL;
          end else if (orphan) begin
            res_valid = in_take; res.error_cause = CAUSE_ORPHAN;
          end else if (interleave) begin
            res_valid = in_take; res.error_cause = CAUSE_INTERLEAVE;
          end else if (length_low == '0 && !is_pong) begin
            res_valid = in_take;
            res.kind = fkind;
            res.frame_end = 1'b1;
            res.is_binary = is_data &&
              ((frame_opcode == OP_CONT) ? first_is_binary : (frame_opcode == OP_BINARY));
            res.message_end = is_data && fin_bit;
          end
        end
      end
      PH_PAY: begin
        res_valid = in_take && !is_pong;
        res.kind = fkind;
        res.has_byte = 1'b1;
        res.payload_byte = ub;
        res.is_binary = is_data && first_is_binary;
        res.frame_end = last;
        res.message_end = last && is_data && fin_bit;
      end
      default: ;
    endcase
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) max_frame_len <= MAX_LEN_RESET;
    else if (cfg_we) max_frame_len <= cfg_data;
  end

  // advance parser state on each taken byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HDR0;
      in_fragment <= 1'b0;
      first_is_binary <= 1'b0;
      mask_index <= '0;
    end else if (in_take) begin
      phase <= phase_next;
      unique case (phase)
        PH_HDR0: begin
          fin_bit <= in_byte[7];
          frame_opcode <= in_byte[3:0];
        end
        PH_HDR1: begin
          mask_index <= '0;
          mask_key <= '0;
          length_big <= 1'b0;
          if (in_byte[6:0] == LEN_EXT16) begin
            length_low <= '0; length_bytes_left <= 4'd2;
          end else if (in_byte[6:0] == LEN_EXT64) begin
            length_low <= '0; length_bytes_left <= 4'd8;
          end else begin
            length_low <= LEN_W'(in_byte[6:0]); length_bytes_left <= 4'd0;
          end
        end
        PH_EXT: begin
          length_big <= length_big || (length_low[LEN_W-1:LEN_W-8] != 8'd0);
          length_low <= {length_low[LEN_W-9:0], in_byte};
          length_bytes_left <= length_bytes_left - 4'd1;
        end
        PH_MASK: begin
          mask_key <= key_full;
          mask_index <= mask_index + 2'd1;
          if (mask_index == 2'd3 && !(too_long || bad_ctrl || orphan || interleave)) begin
            payload_left <= length_low;
            if (frame_opcode == OP_CONT) begin
              if (fin_bit) in_fragment <= 1'b0;
            end else if (frame_opcode == OP_TEXT || frame_opcode == OP_BINARY) begin
              first_is_binary <= (frame_opcode == OP_BINARY);
              in_fragment <= !fin_bit;
            end
          end
        end
        PH_PAY: begin
          mask_index <= mask_index + 2'd1;
          payload_left <= payload_left - LEN_W'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/wsd_queue.sv
// ----------------------------------------------------------------------------
// wsd_queue
// Two-entry result queue that decouples the parser from the output channel.
// ----------------------------------------------------------------------------
module wsd_queue
  import wsd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  result_t     mem [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;
  logic        pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_data  = mem[rd_ptr];

  // hold words until the output side takes them
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0; rd_ptr <= 1'b0; count <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Client-to-server WebSocket deframer: one raw byte in per cycle unless
// stalled, at most one tagged, unmasked result word out.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the queue is not full; every byte is parsed in
// the cycle it is accepted and its result word, if any, enters a two-entry
// queue. Input stalls only while that queue is full. After a protocol error
// the block emits one error word and then swallows all input until reset.
// Well-formed pong frames produce no output.
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [26:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic        has_byte,
  output logic [7:0]  payload_byte,
  output logic        is_binary,
  output logic        frame_end,
  output logic        message_end,
  output logic [2:0]  error_cause
);

  logic    in_take, res_valid, full;
  result_t res, q;

  assign in_stall = full;
  assign in_take  = in_valid && !full;

  wsd_front u_front (
    .clk, .rst, .cfg_we, .cfg_data, .in_take, .in_byte(byte_in),
    .res_valid, .res
  );

  wsd_queue u_queue (
    .clk, .rst, .push(res_valid), .push_data(res), .full,
    .out_valid, .out_stall, .out_data(q)
  );

  assign kind         = q.kind;
  assign has_byte     = q.has_byte;
  assign payload_byte = q.payload_byte;
  assign is_binary    = q.is_binary;
  assign frame_end    = q.frame_end;
  assign message_end  = q.message_end;
  assign error_cause  = q.error_cause;

endmodule

>>> rtl/wsd_checker.sv
// ----------------------------------------------------------------------------
// wsd_checker
// Port-level assertions for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
module wsd_checker
  import wsd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] kind,
  input logic       has_byte,
  input logic       frame_end,
  input logic [2:0] error_cause
);

  // error words carry a cause, others none
  a_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == KIND_ERROR) == (error_cause != CAUSE_NONE)))
    else $error("cause does not match kind");

  // error words carry no byte
  a_err_nobyte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_ERROR) |-> (!has_byte && !frame_end))
    else $error("error word with payload");

  // an empty frame result always ends the frame
  a_empty_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_ERROR && !has_byte) |-> frame_end)
    else $error("empty result not at frame end");

  // output stalled holds valid
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("output dropped while stalled");

  // input is open right after reset
  a_open: assert property (@(posedge clk) $fell(rst) |-> !in_stall)
    else $error("stall after reset");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .kind, .has_byte,
  .frame_end, .error_cause
);
